// ===== src/sliding_window_average_top_macros.svh =====
// assertion macros used by the sliding window average datapath
`ifndef SLIDING_WINDOW_AVERAGE_TOP_MACROS_SVH
`define SLIDING_WINDOW_AVERAGE_TOP_MACROS_SVH

// checked property, disabled while reset is asserted
`define SWA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked property, also evaluated during reset
`define SWA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/swa_pkg.sv =====
// shared types and constants of the sliding window average
package swa_pkg;

  localparam int unsigned WIN_W      = 7;
  localparam int unsigned WIN_RESET  = 8;
  localparam int unsigned MEAN_W     = 24;
  localparam int unsigned HELD_W     = 7;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned MEAN_MAX   = 8388607;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIVIDE,
    ST_OUTPUT
  } swa_state_e;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_load;
    logic div_step;
    logic out_load;
  } swa_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic div_last;
    logic out_free;
  } swa_status_t;

endpackage

// ===== src/swa_ctrl.sv =====
// controller state machine of the sliding window average
module swa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  swa_pkg::swa_status_t status_i,
  output swa_pkg::swa_cmd_t    cmd_o
);

  swa_pkg::swa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      swa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = swa_pkg::ST_UPDATE;
        end
      end
      swa_pkg::ST_UPDATE: begin
        state_d = swa_pkg::ST_LOAD;
      end
      swa_pkg::ST_LOAD: begin
        if (status_i.fill_zero) begin
          state_d = swa_pkg::ST_OUTPUT;
        end else begin
          state_d = swa_pkg::ST_DIVIDE;
        end
      end
      swa_pkg::ST_DIVIDE: begin
        if (status_i.div_last) begin
          state_d = swa_pkg::ST_OUTPUT;
        end
      end
      swa_pkg::ST_OUTPUT: begin
        if (status_i.out_free) begin
          state_d = swa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      swa_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      swa_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
      end
      swa_pkg::ST_LOAD: begin
        cmd_o.div_load = 1'b1;
      end
      swa_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
      end
      swa_pkg::ST_OUTPUT: begin
        cmd_o.out_load = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== src/swa_datapath.sv =====
// sample ring, running sum, serial divider and output register
`include "sliding_window_average_top_macros.svh"

module swa_datapath #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned IN_DATA_W   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [swa_pkg::WIN_W-1:0]       cfg_wdata_i,
  input  logic [IN_DATA_W-1:0]            in_data_i,
  input  logic                            in_action_i,
  input  swa_pkg::swa_cmd_t               cmd_i,
  output swa_pkg::swa_status_t            status_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [swa_pkg::MEAN_W-1:0]      out_mean_o,
  output logic                            out_mean_valid_o,
  output logic [swa_pkg::HELD_W-1:0]      out_held_o
);

  localparam int unsigned FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PTR_W  = $clog2(MAX_WINDOW);
  localparam int unsigned SUM_W  = SAMPLE_BITS + FILL_W;
  localparam int unsigned NUM_W  = SUM_W + 8;
  localparam int unsigned CNT_W  = $clog2(NUM_W);
  localparam int unsigned CMP_W  = (FILL_W > swa_pkg::WIN_W) ? FILL_W : swa_pkg::WIN_W;
  localparam int unsigned QX_W   = (NUM_W > swa_pkg::MEAN_W) ? NUM_W : swa_pkg::MEAN_W + 1;

  logic [swa_pkg::WIN_W-1:0] win_q;
  logic                      act_q;
  logic [SAMPLE_BITS-1:0]    smp_q;
  logic [SAMPLE_BITS-1:0]    ring [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0]    rd_q;
  logic [PTR_W-1:0]          wp_q, wp_d;
  logic [FILL_W-1:0]         fill_q, fill_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [FILL_W:0]           old_raw, old_wrap;
  logic [PTR_W-1:0]          old_addr;
  logic [CMP_W-1:0]          win_x, win_eff, fill_x;
  logic                      full;
  logic signed [SUM_W-1:0]   smp_x, old_x;

  logic [NUM_W-1:0]          quo_q, quo_d;
  logic [FILL_W-1:0]         rem_q, rem_d;
  logic [FILL_W-1:0]         dvs_q;
  logic [FILL_W:0]           trial;
  logic                      neg_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [SUM_W-1:0]          sum_mag;

  logic [QX_W-1:0]           quo_x;
  logic [swa_pkg::MEAN_W-1:0] mean_d;
  logic                      out_valid_q;
  logic [swa_pkg::MEAN_W-1:0] out_mean_q;
  logic                      out_mvalid_q;
  logic [swa_pkg::HELD_W-1:0] out_held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= swa_pkg::WIN_W'(swa_pkg::WIN_RESET);
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q <= in_action_i;
      smp_q <= in_data_i[SAMPLE_BITS-1:0];
    end
  end

  // effective window and oldest entry
  always_comb begin
    win_x = CMP_W'(win_q);
    if (win_x == '0) begin
      win_eff = CMP_W'(1);
    end else if (win_x > CMP_W'(MAX_WINDOW)) begin
      win_eff = CMP_W'(MAX_WINDOW);
    end else begin
      win_eff = win_x;
    end
    fill_x  = CMP_W'(fill_q);
    full    = (fill_x >= win_eff);
    old_raw = (FILL_W + 1)'(wp_q) + (FILL_W + 1)'(MAX_WINDOW) - (FILL_W + 1)'(fill_q);
    if (old_raw >= (FILL_W + 1)'(MAX_WINDOW)) begin
      old_wrap = old_raw - (FILL_W + 1)'(MAX_WINDOW);
    end else begin
      old_wrap = old_raw;
    end
    old_addr = old_wrap[PTR_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    rd_q <= ring[old_addr];
    if (cmd_i.update && (act_q == swa_pkg::ACT_ADD)) begin
      ring[wp_q] <= smp_q;
    end
  end

  always_comb begin
    smp_x  = SUM_W'($signed(smp_q));
    old_x  = full ? SUM_W'($signed(rd_q)) : '0;
    wp_d   = wp_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    if (cmd_i.update) begin
      if (act_q == swa_pkg::ACT_CLEAR) begin
        wp_d   = '0;
        fill_d = '0;
        sum_d  = '0;
      end else begin
        sum_d  = sum_q - old_x + smp_x;
        fill_d = full ? fill_q : fill_q + FILL_W'(1);
        wp_d   = (wp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign trial   = {rem_q, quo_q[NUM_W-1]};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    if (cmd_i.div_load) begin
      quo_d = {sum_mag, 8'b0};
      rem_d = '0;
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = FILL_W'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[FILL_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (cmd_i.div_load) begin
      dvs_q <= fill_q;
      neg_q <= sum_q[SUM_W-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_load) begin
      cnt_q <= CNT_W'(NUM_W - 1);
    end else if (cmd_i.div_step && (cnt_q != '0)) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // sign and saturation of the quotient
  always_comb begin
    quo_x = QX_W'(quo_q);
    if (fill_q == '0) begin
      mean_d = '0;
    end else if (neg_q) begin
      if (quo_x > QX_W'(swa_pkg::MEAN_MAX) + QX_W'(1)) begin
        mean_d = {1'b1, {(swa_pkg::MEAN_W - 1){1'b0}}};
      end else begin
        mean_d = swa_pkg::MEAN_W'(-quo_x);
      end
    end else begin
      if (quo_x > QX_W'(swa_pkg::MEAN_MAX)) begin
        mean_d = swa_pkg::MEAN_W'(swa_pkg::MEAN_MAX);
      end else begin
        mean_d = swa_pkg::MEAN_W'(quo_x);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_mean_q   <= mean_d;
      out_mvalid_q <= (fill_q != '0);
      out_held_q   <= swa_pkg::HELD_W'(fill_q);
    end
  end

  assign status_o.fill_zero = (fill_q == '0);
  assign status_o.div_last  = (cnt_q == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign out_mean_o       = out_mean_q;
  assign out_mean_valid_o = out_mvalid_q;
  assign out_held_o       = out_held_q;

  `SWA_ASSERT(a_fill_bound, fill_q <= FILL_W'(MAX_WINDOW), "fill count above ring depth")
  `SWA_ASSERT(a_wp_bound, wp_q <= PTR_W'(MAX_WINDOW - 1), "write pointer out of ring")
  `SWA_ASSERT(a_clear_empties, cmd_i.update && (act_q == swa_pkg::ACT_CLEAR) |=> fill_q == '0, "clear did not empty the window")
  `SWA_ASSERT(a_empty_result, out_valid_q && !out_mvalid_q |-> (out_mean_q == '0) && (out_held_q == '0), "empty result carries data")

endmodule

// ===== src/sliding_window_average_top.sv =====
// a request passes through the states update, load, divide and output; divide is skipped when no sample is held
// NUM_W = SAMPLE_BITS + clog2(MAX_WINDOW + 1) + 8 quotient bits, one per divider cycle
// a new request is taken only in idle, once the previous result is in the output register
// one result may wait in the output register; a second one stalls until it is taken
// reset: asynchronous active low, empties the window and sets window_size to 8
// the sample ring itself is not cleared; only entries written since the last clear are read
module sliding_window_average_top #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [swa_pkg::WIN_W-1:0]              cfg_wdata_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // sample in the low bits, zero padded to whole bytes
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  // action
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // mean_value [23:0], held_count [30:24], zero at bit 31
  output logic [swa_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // mean_valid
  output logic                                   m_axis_tuser
);

  localparam int unsigned IN_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  swa_pkg::swa_cmd_t          cmd;
  swa_pkg::swa_status_t       status;
  logic [swa_pkg::MEAN_W-1:0] mean;
  logic [swa_pkg::HELD_W-1:0] held;

  swa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swa_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IN_DATA_W   (IN_DATA_W)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_data_i        (s_axis_tdata),
    .in_action_i      (s_axis_tuser),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .out_mean_o       (mean),
    .out_mean_valid_o (m_axis_tuser),
    .out_held_o       (held)
  );

  assign m_axis_tdata = {
    {(swa_pkg::OUT_DATA_W - swa_pkg::MEAN_W - swa_pkg::HELD_W){1'b0}}, held, mean
  };

endmodule
